@@ rtl/core/snr_pkg.sv @@
// Shared types and constants of the sequence number resequencer.
// Used by the slot engine, the top level and the port checker.
package snr_pkg;

  localparam int SEQ_W      = 8;
  localparam int SEQ_SLOTS  = 256;
  localparam int RESULT_CAP = 64;
  localparam int CNT_W      = 7;
  localparam int MAX_HELD_W = 6;
  localparam logic [MAX_HELD_W-1:0] MAX_HELD_RST = 6'd32;

  // One slot of the reorder memory
  typedef struct packed {
    logic        valid;
    logic [15:0] length;
    logic [15:0] tag;
  } snr_slot_t;

  // Per-source bookkeeping word
  typedef struct packed {
    logic             known;
    logic [SEQ_W-1:0] last;
    logic [CNT_W-1:0] cnt;
  } snr_src_state_t;

  // One delivered descriptor
  typedef struct packed {
    logic [1:0]       source;
    logic [SEQ_W-1:0] seq;
    logic [15:0]      tag;
    logic [15:0]      length;
    logic             after_gap;
    logic             last;
  } snr_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_RUN_RD,
    ST_RUN_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_FLUSH
  } snr_state_t;

endpackage

@@ rtl/core/snr_ram.sv @@
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued.
module snr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/snr_engine.sv @@
// Resequencing engine: read-modify-write sequencer over the slot and source RAMs.
// Depends on snr_pkg; drives two snr_ram instances owned by the top level.
module snr_engine
  import snr_pkg::*;
#(
  parameter int SOURCES = 4,
  parameter int SRC_W   = 2,
  parameter int AW      = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_source,
  input  logic [SEQ_W-1:0]      in_seq,
  input  logic [15:0]           in_tag,
  input  logic [15:0]           in_length,
  input  logic [MAX_HELD_W-1:0] max_held,
  output logic                  slot_rd_en,
  output logic [AW-1:0]         slot_rd_addr,
  input  snr_slot_t             slot_rd_data,
  output logic                  slot_wr_en,
  output logic [AW-1:0]         slot_wr_addr,
  output snr_slot_t             slot_wr_data,
  output logic                  src_rd_en,
  output logic [SRC_W-1:0]      src_rd_addr,
  input  snr_src_state_t        src_rd_data,
  output logic                  src_wr_en,
  output logic [SRC_W-1:0]      src_wr_addr,
  output snr_src_state_t        src_wr_data,
  input  logic                  out_free,
  output logic                  res_push,
  output snr_result_t           res
);

  localparam int SLOT_DEPTH = SOURCES * SEQ_SLOTS;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(RESULT_CAP);

  snr_state_t       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  snr_result_t      pend_r, pend_nxt;
  logic [1:0]       src_r, src_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [15:0]      tag_r, tag_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [SEQ_W-1:0] pos_r, pos_nxt;
  logic [SEQ_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [SEQ_W-1:0] srch_r, srch_nxt;
  logic             first_r, first_nxt;
  logic             gap_r, gap_nxt;
  logic             phase_r, phase_nxt;

  logic [SRC_W-1:0] src_idx;
  logic             in_src_ok;
  logic [CNT_W-1:0] cnt_base;

  assign src_idx   = SRC_W'(src_r);
  assign in_src_ok = 32'(in_source) < SOURCES;
  assign cnt_base  = (slot_rd_data.valid && src_rd_data.cnt != '0) ?
                     src_rd_data.cnt - 1'b1 : src_rd_data.cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    src_r   <= src_nxt;
    seq_r   <= seq_nxt;
    tag_r   <= tag_nxt;
    len_r   <= len_nxt;
    pos_r   <= pos_nxt;
    last_r  <= last_nxt;
    cnt_r   <= cnt_nxt;
    n_r     <= n_nxt;
    srch_r  <= srch_nxt;
    first_r <= first_nxt;
    gap_r   <= gap_nxt;
    phase_r <= phase_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    src_nxt        = src_r;
    seq_nxt        = seq_r;
    tag_nxt        = tag_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    srch_nxt       = srch_r;
    first_nxt      = first_r;
    gap_nxt        = gap_r;
    phase_nxt      = phase_r;

    in_ready     = 1'b0;
    slot_rd_en   = 1'b0;
    slot_rd_addr = {src_idx, pos_r};
    slot_wr_en   = 1'b0;
    slot_wr_addr = {src_idx, pos_r};
    slot_wr_data = '0;
    src_rd_en    = 1'b0;
    src_rd_addr  = src_idx;
    src_wr_en    = 1'b0;
    src_wr_addr  = src_idx;
    src_wr_data  = '{known: 1'b1, last: last_r, cnt: cnt_r};
    res_push     = 1'b0;
    res          = pend_r;

    case (state_r)
      ST_CLEAR: begin
        slot_wr_en   = 1'b1;
        slot_wr_addr = clr_r;
        src_wr_en    = 1'b1;
        src_wr_addr  = clr_r[SRC_W-1:0];
        src_wr_data  = '0;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == AW'(SLOT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // zero length or unknown source: drop without touching state
        if (in_valid && in_length != '0 && in_src_ok) begin
          src_nxt      = in_source;
          seq_nxt      = in_seq;
          tag_nxt      = in_tag;
          len_nxt      = in_length;
          src_rd_en    = 1'b1;
          src_rd_addr  = SRC_W'(in_source);
          slot_rd_en   = 1'b1;
          slot_rd_addr = {SRC_W'(in_source), in_seq};
          state_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        slot_wr_en   = 1'b1;
        slot_wr_addr = {src_idx, seq_r};
        slot_wr_data = '{valid: 1'b1, length: len_r, tag: tag_r};
        pos_nxt      = src_rd_data.known ? src_rd_data.last + 1'b1 : seq_r;
        last_nxt     = src_rd_data.last;
        cnt_nxt      = cnt_base + 1'b1;
        n_nxt        = '0;
        first_nxt    = 1'b1;
        gap_nxt      = 1'b0;
        phase_nxt    = 1'b0;
        state_nxt    = ST_RUN_RD;
      end
      ST_RUN_RD: begin
        slot_rd_en = 1'b1;
        state_nxt  = ST_RUN_CHK;
      end
      ST_RUN_CHK: begin
        if (slot_rd_data.valid && n_r != CAP) begin
          // hold here while the previous result cannot leave
          if (!pend_valid_r || out_free) begin
            res_push       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{source: src_r, seq: pos_r, tag: slot_rd_data.tag,
                               length: slot_rd_data.length,
                               after_gap: gap_r && first_r, last: 1'b0};
            slot_wr_en     = 1'b1;
            cnt_nxt        = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
            last_nxt       = pos_r;
            pos_nxt        = pos_r + 1'b1;
            n_nxt          = n_r + 1'b1;
            first_nxt      = 1'b0;
            state_nxt      = ST_RUN_RD;
          end
        end else if (!phase_r && cnt_r > CNT_W'(max_held) && n_r != CAP) begin
          // expected slot is empty: search onward from the one after it
          pos_nxt   = last_r + 2'd2;
          srch_nxt  = '0;
          state_nxt = ST_SRCH_RD;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SRCH_RD: begin
        slot_rd_en = 1'b1;
        state_nxt  = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (slot_rd_data.valid) begin
          // read data holds, so the run check can use it directly
          gap_nxt   = 1'b1;
          first_nxt = 1'b1;
          phase_nxt = 1'b1;
          state_nxt = ST_RUN_CHK;
        end else if (srch_r == '1) begin
          state_nxt = ST_FLUSH;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          srch_nxt  = srch_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_FLUSH: begin
        src_wr_en = 1'b1;
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          res_push       = 1'b1;
          res.last       = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sequence_number_resequencer_unit.sv @@
// Top level of the per-source packet resequencer: config register, RAMs,
// engine and output register. Depends on snr_pkg, snr_ram and snr_engine.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | source, seq, tag, length
//   out_    | output    | out_valid / out_ready| source, seq, tag, length, after_gap, last
//   cfg_    | input     | cfg_wr_en            | max_held (6 bits)
//
// One descriptor at a time. Every probe of the slot RAM is a read state and then a
// check state; a gap search probes at most 256 slots and resumes the run at a held one.
// After reset a clearing pass writes every slot, SOURCES*256 of them (1024 by default),
// with in_ready low; configuration writes are taken throughout.
// A full output register stalls the engine only when a further result is ready.
module sequence_number_resequencer_unit
  import snr_pkg::*;
#(
  parameter int SOURCES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_source,
  input  logic [SEQ_W-1:0]      in_seq,
  input  logic [15:0]           in_tag,
  input  logic [15:0]           in_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_source,
  output logic [SEQ_W-1:0]      out_seq,
  output logic [15:0]           out_tag,
  output logic [15:0]           out_length,
  output logic                  out_after_gap,
  output logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [MAX_HELD_W-1:0] cfg_wr_data
);

  localparam int SRC_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int AW         = SRC_W + SEQ_W;
  localparam int SLOT_DEPTH = SOURCES * SEQ_SLOTS;

  logic [MAX_HELD_W-1:0] max_held_r;
  logic                  out_valid_r;
  snr_result_t           out_res_r;

  logic           slot_rd_en, slot_wr_en;
  logic [AW-1:0]  slot_rd_addr, slot_wr_addr;
  snr_slot_t      slot_rd_data, slot_wr_data;
  logic           src_rd_en, src_wr_en;
  logic [SRC_W-1:0] src_rd_addr, src_wr_addr;
  snr_src_state_t src_rd_data, src_wr_data;
  logic           out_free;
  logic           res_push;
  snr_result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_held_r <= MAX_HELD_RST;
    end else if (cfg_wr_en) begin
      max_held_r <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_source    = out_res_r.source;
  assign out_seq       = out_res_r.seq;
  assign out_tag       = out_res_r.tag;
  assign out_length    = out_res_r.length;
  assign out_after_gap = out_res_r.after_gap;
  assign out_last      = out_res_r.last;

  snr_ram #(
    .WIDTH ($bits(snr_slot_t)),
    .DEPTH (SLOT_DEPTH),
    .AW    (AW)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  snr_ram #(
    .WIDTH ($bits(snr_src_state_t)),
    .DEPTH (1 << SRC_W),
    .AW    (SRC_W)
  ) u_src_ram (
    .clk     (clk),
    .rd_en   (src_rd_en),
    .rd_addr (src_rd_addr),
    .rd_data (src_rd_data),
    .wr_en   (src_wr_en),
    .wr_addr (src_wr_addr),
    .wr_data (src_wr_data)
  );

  snr_engine #(
    .SOURCES (SOURCES),
    .SRC_W   (SRC_W),
    .AW      (AW)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_source    (in_source),
    .in_seq       (in_seq),
    .in_tag       (in_tag),
    .in_length    (in_length),
    .max_held     (max_held_r),
    .slot_rd_en   (slot_rd_en),
    .slot_rd_addr (slot_rd_addr),
    .slot_rd_data (slot_rd_data),
    .slot_wr_en   (slot_wr_en),
    .slot_wr_addr (slot_wr_addr),
    .slot_wr_data (slot_wr_data),
    .src_rd_en    (src_rd_en),
    .src_rd_addr  (src_rd_addr),
    .src_rd_data  (src_rd_data),
    .src_wr_en    (src_wr_en),
    .src_wr_addr  (src_wr_addr),
    .src_wr_data  (src_wr_data),
    .out_free     (out_free),
    .res_push     (res_push),
    .res          (res)
  );

endmodule

@@ rtl/core/snr_checker.sv @@
// Port-level checker for the resequencer, bound to the top level.
// Depends on snr_pkg for field widths.
module snr_checker
  import snr_pkg::*;
#(
  parameter int SOURCES = 4
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_source,
  input logic [15:0]      in_length,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_source,
  input logic [SEQ_W-1:0] out_seq,
  input logic [15:0]      out_tag,
  input logic [15:0]      out_length,
  input logic             out_after_gap,
  input logic             out_last
);

  // a stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source) && $stable(out_seq) &&
      $stable(out_tag) && $stable(out_length) && $stable(out_after_gap) &&
      $stable(out_last))
    else $error("output transaction changed while stalled");

  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length != '0)
    else $error("zero-length packet delivered");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_length != '0 && 32'(in_source) < SOURCES |=> !in_ready)
    else $error("engine took a new transaction while processing one");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without a transaction");

endmodule

bind sequence_number_resequencer_unit snr_checker #(.SOURCES(SOURCES)) u_snr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_source     (in_source),
  .in_length     (in_length),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_source    (out_source),
  .out_seq       (out_seq),
  .out_tag       (out_tag),
  .out_length    (out_length),
  .out_after_gap (out_after_gap),
  .out_last      (out_last)
);

@@ dv/sequence_number_resequencer_unit_tb.sv @@
// Self-checking testbench for the per-source packet resequencer.
// Drives descriptors against a local reorder predictor and checks every delivery.
// Depends on snr_pkg and sequence_number_resequencer_unit.
`timescale 1ns / 1ps

module sequence_number_resequencer_unit_tb
  import snr_pkg::*;
();

  localparam int NSRC         = 4;
  localparam int IDLE_WAIT    = 1500;    // longest pass: full run plus a full gap search
  localparam int DRAIN_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_source;
  logic [SEQ_W-1:0]      in_seq;
  logic [15:0]           in_tag;
  logic [15:0]           in_length;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_source;
  logic [SEQ_W-1:0]      out_seq;
  logic [15:0]           out_tag;
  logic [15:0]           out_length;
  logic                  out_after_gap;
  logic                  out_last;
  logic                  cfg_wr_en;
  logic [MAX_HELD_W-1:0] cfg_wr_data;

  sequence_number_resequencer_unit #(
    .SOURCES(NSRC)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_source    (in_source),
    .in_seq       (in_seq),
    .in_tag       (in_tag),
    .in_length    (in_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_source   (out_source),
    .out_seq      (out_seq),
    .out_tag      (out_tag),
    .out_length   (out_length),
    .out_after_gap(out_after_gap),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Reorder predictor state
  bit                    src_known [NSRC];
  logic [SEQ_W-1:0]      src_last  [NSRC];
  logic [CNT_W-1:0]      src_held  [NSRC];
  bit                    slot_full [NSRC][SEQ_SLOTS];
  logic [15:0]           slot_tag  [NSRC][SEQ_SLOTS];
  logic [15:0]           slot_len  [NSRC][SEQ_SLOTS];
  logic [MAX_HELD_W-1:0] max_held;

  snr_result_t      batch[$];
  snr_result_t      pending_deliveries[$];
  snr_result_t      seen_want;
  logic [SEQ_W-1:0] seq_list[$];

  int  error_count;
  int  desc_count;
  int  dropped_count;
  int  delivery_count;
  int  gap_count;
  int  setting_count;
  int  stall_left;
  bit  in_idle_on;
  bit  rdy_idle_on;

  function automatic void reset_predictor();
    for (int s = 0; s < NSRC; s++) begin
      src_known[s] = 1'b0;
      src_last[s]  = '0;
      src_held[s]  = '0;
      for (int p = 0; p < SEQ_SLOTS; p++) begin
        slot_full[s][p] = 1'b0;
      end
    end
    max_held = MAX_HELD_RST;
  endfunction

  // Drain consecutive held slots from start into the batch, up to the result bound
  function automatic void deliver_run_from(int src, logic [SEQ_W-1:0] start, bit gap);
    logic [SEQ_W-1:0] pos;
    bit               first;
    snr_result_t      r;
    pos   = start;
    first = 1'b1;
    while (batch.size() < RESULT_CAP && slot_full[src][pos]) begin
      r.source    = src[1:0];
      r.seq       = pos;
      r.tag       = slot_tag[src][pos];
      r.length    = slot_len[src][pos];
      r.after_gap = gap && first;
      r.last      = 1'b0;
      batch.insert(batch.size(), r);
      first = 1'b0;
      slot_full[src][pos] = 1'b0;
      if (src_held[src] != 0) src_held[src]--;
      src_last[src] = pos;
      pos++;
    end
  endfunction

  function automatic void predict_delivery(logic [1:0] src, logic [SEQ_W-1:0] seq,
                                           logic [15:0] tag, logic [15:0] len);
    logic [SEQ_W-1:0] start;
    logic [SEQ_W-1:0] probe;
    int               i;
    if (len == 0) return;
    if (!src_known[src]) begin
      src_known[src] = 1'b1;
      start = seq;
    end else begin
      start = src_last[src] + 8'd1;
    end
    // overwrite keeps the count
    if (slot_full[src][seq] && src_held[src] != 0) src_held[src]--;
    slot_full[src][seq] = 1'b1;
    slot_tag[src][seq]  = tag;
    slot_len[src][seq]  = len;
    src_held[src]++;
    batch.delete();
    deliver_run_from(src, start, 1'b0);
    if (src_held[src] > max_held && batch.size() < RESULT_CAP) begin
      // expected slot is empty: search past it for the next held one
      probe = src_last[src] + 8'd2;
      i = 0;
      while (i < SEQ_SLOTS && !slot_full[src][probe]) begin
        probe++;
        i++;
      end
      if (slot_full[src][probe]) deliver_run_from(src, probe, 1'b1);
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) pending_deliveries.insert(pending_deliveries.size(), batch[k]);
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd1;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [15:0] rand_tag();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void shuffle_seq_list();
    int               j;
    logic [SEQ_W-1:0] t;
    for (int i = seq_list.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = seq_list[i];
      seq_list[i] = seq_list[j];
      seq_list[j] = t;
    end
  endfunction

  task automatic send_desc(input logic [1:0] src, input logic [SEQ_W-1:0] seq,
                           input logic [15:0] tag, input logic [15:0] len);
    int gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_source <= src;
    in_seq    <= seq;
    in_tag    <= tag;
    in_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_delivery(src, seq, tag, len);
    if (len == 0) dropped_count++;
    else desc_count++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (pending_deliveries.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Write only with the engine idle: nothing pending and a full pass elapsed
  task automatic write_max_held(input logic [MAX_HELD_W-1:0] value);
    release_input();
    wait_drained();
    repeat (IDLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    max_held = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // First packets, in-order and reordered runs, drop, overwrite, stale, wrap
  task automatic test_first_and_reorder();
    send_desc(2'd0, 8'd0, 16'h0000, 16'd1);
    send_desc(2'd0, 8'd2, 16'hFFFF, 16'hFFFF);
    send_desc(2'd0, 8'd1, 16'h1234, 16'd1);
    send_desc(2'd0, 8'd3, 16'hDEAD, 16'd0);
    send_desc(2'd0, 8'd3, 16'h00C3, 16'd7);
    send_desc(2'd1, 8'd10, 16'h0A0A, 16'd64);
    send_desc(2'd1, 8'd12, 16'hAAAA, 16'd100);
    send_desc(2'd1, 8'd12, 16'h5555, 16'd200);
    send_desc(2'd1, 8'd11, 16'h0B0B, 16'd300);
    send_desc(2'd1, 8'd5, 16'h0505, 16'd5);
    send_desc(2'd2, 8'd255, 16'hFFFF, 16'hFFFF);
    send_desc(2'd2, 8'd0, 16'h0000, 16'h8000);
    send_desc(2'd2, 8'd2, 16'h0202, 16'd2);
    send_desc(2'd2, 8'd1, 16'h0101, 16'd1);
    send_desc(2'd3, 8'd128, 16'h8000, 16'h8000);
    send_desc(2'd3, 8'd127, 16'h7FFF, 16'h7FFF);
    send_desc(2'd3, 8'd129, 16'h8181, 16'd9);
  endtask

  // Limit zero: any hole is skipped at once, gap flagged on the first packet after it
  task automatic test_gap_skip();
    write_max_held(6'd0);
    send_desc(2'd2, 8'd5, 16'h0505, 16'd50);
    send_desc(2'd1, 8'd14, 16'h0E0E, 16'd14);
    send_desc(2'd1, 8'd16, 16'h1010, 16'd16);
    send_desc(2'd3, 8'd131, 16'h8383, 16'd31);
  endtask

  // Hold 63 behind one hole, then fill it: one input delivers the bound of 64
  task automatic test_result_cap();
    logic [SEQ_W-1:0] base;
    write_max_held(6'd63);
    base = src_last[0] + 8'd1;
    seq_list.delete();
    for (int k = 1; k < RESULT_CAP; k++) seq_list.insert(seq_list.size(), base + 8'(k));
    shuffle_seq_list();
    foreach (seq_list[j]) send_desc(2'd0, seq_list[j], rand_tag(), rand_len());
    send_desc(2'd0, base, rand_tag(), rand_len());
  endtask

  // Lowering the limit with 63 held: the next input delivers a single skipped run
  task automatic test_limit_lowered();
    logic [SEQ_W-1:0] base;
    base = src_last[0] + 8'd1;
    seq_list.delete();
    for (int k = 1; k < RESULT_CAP; k++) seq_list.insert(seq_list.size(), base + 8'(k));
    shuffle_seq_list();
    foreach (seq_list[j]) send_desc(2'd0, seq_list[j], rand_tag(), rand_len());
    write_max_held(6'd1);
    send_desc(2'd0, base + 8'd65, rand_tag(), rand_len());
  endtask

  // Per-source streams in shuffled windows with losses, repeats, strays and drops
  task automatic test_random_streams();
    logic [SEQ_W-1:0]      next_seq [NSRC];
    logic [SEQ_W-1:0]      base;
    logic [1:0]            src;
    logic [MAX_HELD_W-1:0] limit_val;
    int                    sent;
    int                    size;
    int                    r;
    for (int s = 0; s < NSRC; s++) next_seq[s] = src_last[s] + 8'd1;
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       limit_val = 6'($urandom_range(0, 63));
        1:       limit_val = 6'd62;
        2:       limit_val = 6'($urandom_range(1, 6));
        default: limit_val = MAX_HELD_RST;
      endcase
      write_max_held(limit_val);
      in_idle_on  = (phase != 1);
      rdy_idle_on = (phase != 1);
      while (sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        src = 2'($urandom_range(0, NSRC - 1));
        if ($urandom_range(0, 9) == 0) next_seq[src] = src_last[src] + 8'd1;
        size = $urandom_range(1, 8);
        base = next_seq[src];
        seq_list.delete();
        for (int k = 0; k < size; k++) seq_list.insert(seq_list.size(), base + 8'(k));
        shuffle_seq_list();
        r = $urandom_range(0, 99);
        if (r < 12 && size > 1) seq_list.delete($urandom_range(0, size - 1));
        else if (r < 22) seq_list.insert(seq_list.size(), seq_list[$urandom_range(0, size - 1)]);
        foreach (seq_list[j]) begin
          send_desc(src, seq_list[j], rand_tag(), rand_len());
          sent++;
        end
        next_seq[src] = base + 8'(size);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_desc(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), rand_tag(), 16'd0);
        end else if (r < 14) begin
          send_desc(src, 8'($urandom_range(0, 255)), rand_tag(), rand_len());
          sent++;
        end else if (r < 18) begin
          // hold off until everything owed has come out
          release_input();
          wait_drained();
        end
      end
    end
    in_idle_on  = 1'b1;
    rdy_idle_on = 1'b1;
  endtask

  // Result receiver with random back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(rdy_idle_on);
    end
  end

  // Compare every delivered transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_deliveries.size() == 0) begin
        error_count++;
        $display("%0t: unexpected delivery src %0d seq %0d tag %h len %h gap %b last %b",
                 $time, out_source, out_seq, out_tag, out_length, out_after_gap, out_last);
      end else begin
        seen_want = pending_deliveries.pop_front();
        delivery_count++;
        if (out_after_gap) gap_count++;
        if (seen_want.source !== out_source || seen_want.seq !== out_seq ||
            seen_want.tag !== out_tag || seen_want.length !== out_length ||
            seen_want.after_gap !== out_after_gap || seen_want.last !== out_last) begin
          error_count++;
          $display("%0t: delivery mismatch, expected src %0d seq %0d tag %h len %h gap %b last %b",
                   $time, seen_want.source, seen_want.seq, seen_want.tag,
                   seen_want.length, seen_want.after_gap, seen_want.last);
          $display("%0t:                    actual src %0d seq %0d tag %h len %h gap %b last %b",
                   $time, out_source, out_seq, out_tag, out_length,
                   out_after_gap, out_last);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_source   = '0;
    in_seq      = '0;
    in_tag      = '0;
    in_length   = '0;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    stall_left  = 0;
    in_idle_on  = 1'b1;
    rdy_idle_on = 1'b1;
    error_count    = 0;
    desc_count     = 0;
    dropped_count  = 0;
    delivery_count = 0;
    gap_count      = 0;
    setting_count  = 0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_and_reorder();
    test_gap_skip();
    test_result_cap();
    test_limit_lowered();
    test_random_streams();

    release_input();
    wait_drained();
    repeat (IDLE_WAIT) @(posedge clk);
    if (pending_deliveries.size() != 0) begin
      error_count += pending_deliveries.size();
      $display("%0t: %0d predicted deliveries never arrived", $time,
               pending_deliveries.size());
    end
    $display("Covered %0d descriptors and %0d zero-length drops, %0d deliveries,",
             desc_count, dropped_count, delivery_count);
    $display("%0d of them after skipped numbers, over %0d max_held settings.",
             gap_count, setting_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("%0t: timeout, run did not finish", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
